// File: rtl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg: shared types and constants for the flow priority table
// Request/result structs, request codes, status codes and the entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package fpt_pkg;

    localparam int unsigned FPT_DEPTH = 64;

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_DEL_ID   = 3'd1,
        REQ_DEL_POS  = 3'd2,
        REQ_FIND_POS = 3'd3,
        REQ_SET_EXEC = 3'd4,
        REQ_PEEK     = 3'd5,
        REQ_POP      = 3'd6,
        REQ_NONE     = 3'd7
    } req_code_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  flow_id;
        logic [15:0] arrival;
        logic [15:0] transmit_len;
        logic [7:0]  prio;
        logic [7:0]  orig_position;
        logic        exec_flag;
    } fpt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_flow_id;
        logic [15:0] out_arrival;
        logic [15:0] out_transmit_len;
        logic [7:0]  out_prio;
        logic [7:0]  out_position;
        logic        out_exec;
        logic [6:0]  entry_count;
    } fpt_res_t;

    // stored entry, 57 data bits
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arr;
        logic [15:0] tx;
        logic [7:0]  pri;
        logic [7:0]  pos;
        logic        ex;
    } fpt_entry_t;

    // true when a must be served before b
    function automatic logic fpt_ahead(input fpt_entry_t a, input fpt_entry_t b);
        logic r;
        if (a.ex != b.ex)        r = a.ex;
        else if (a.pri != b.pri) r = (a.pri < b.pri);
        else if (a.arr != b.arr) r = (a.arr < b.arr);
        else if (a.tx != b.tx)   r = (a.tx < b.tx);
        else                     r = (a.pos < b.pos);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/flow_priority_table_unit.sv
// ----------------------------------------------------------------------------
// flow_priority_table_unit: bounded flow table with best-entry selection
// Insert, delete, look up, flag, peek and pop over a table of flow entries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and pulse start; the request is taken on a
//   clock edge where start is high and busy is low. busy rises only when the
//   two-deep request queue is full.
//   Result channel: done is high for exactly one cycle with rsp valid. The
//   receiver cannot stall; every request yields exactly one result.
// Request flow:
//   Each request walks the entry memory one slot per cycle through its single
//   registered read port, then the engine applies the request and registers
//   its result. A queued request is taken at the edge that ends the done
//   cycle, so the engine takes no new request before the last result is out.
//   Requests are served strictly in order, one at a time.
// Best entry: executing flag set first, then lowest priority, earliest
//   arrival, shortest transmission, lowest position, lowest slot.
// Reset: asynchronous, clears the queue, all slot valid bits and the count;
//   the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_priority_table_unit #(
    parameter int unsigned TABLE_DEPTH = fpt_pkg::FPT_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  fpt_pkg::fpt_req_t    req,
    output logic                 done,
    output fpt_pkg::fpt_res_t    rsp
);
    import fpt_pkg::*;

    fpt_req_t head_data;
    logic     head_valid;
    logic     head_pop;
    logic     full;
    logic     engine_idle;

    assign busy = full;

    fpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (start),
        .push_data  (req),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (head_pop)
    );

    fpt_back #(.DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (head_valid),
        .req_data  (head_data),
        .req_pop   (head_pop),
        .res_valid (done),
        .res_data  (rsp),
        .idle      (engine_idle)
    );

    // a result only comes from a request the engine finished
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(!engine_idle))
        else $error("result without active request");

    // the engine only takes a request when it is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> engine_idle && head_valid)
        else $error("request taken while busy");

    // status is never an unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.status <= ST_FULL)
        else $error("bad status code");

endmodule

`default_nettype wire

// File: rtl/fpt_front.sv
// ----------------------------------------------------------------------------
// fpt_front: request intake
// Two-entry request queue; accepts while not full, hands requests to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  fpt_pkg::fpt_req_t    push_data,
    output logic                 full,
    output logic                 head_valid,
    output fpt_pkg::fpt_req_t    head_data,
    input  wire logic            pop
);
    import fpt_pkg::*;

    fpt_req_t   q_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push && !full) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else begin
            if (push && !full) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && head_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && head_valid};
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpt_back.sv
// ----------------------------------------------------------------------------
// fpt_back: table engine
// Scans the entry memory one slot a cycle, then applies and reports.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_back #(
    parameter int unsigned DEPTH = fpt_pkg::FPT_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  fpt_pkg::fpt_req_t    req_data,
    output logic                 req_pop,
    output logic                 res_valid,
    output fpt_pkg::fpt_res_t    res_data,
    output logic                 idle
);
    import fpt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_RD, S_RDW, S_DONE} state_t;

    fpt_entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    state_t     state_reg;
    fpt_req_t   cur_reg;
    logic [AW:0] idx_reg;
    logic [AW-1:0] rd_idx;
    fpt_entry_t rd_reg;
    logic       rd_v_reg;
    logic [AW-1:0] rd_a_reg;
    logic       hit_reg;
    logic [AW-1:0] hit_idx_reg;
    fpt_entry_t hit_ent_reg;
    logic       free_reg;
    logic [AW-1:0] free_idx_reg;
    logic [CW-1:0] count_reg;
    logic       res_valid_reg;
    fpt_res_t   res_reg;

    logic match;
    logic better;
    req_code_t rq;

    assign rq = req_code_t'(cur_reg.req_type);
    assign rd_idx = idx_reg[AW-1:0];

    always_comb begin
        unique case (rq)
            REQ_DEL_ID, REQ_SET_EXEC:  match = (rd_reg.id == cur_reg.flow_id);
            REQ_DEL_POS, REQ_FIND_POS: match = (rd_reg.pos == cur_reg.orig_position);
            default:                   match = 1'b0;
        endcase
        better = !hit_reg || fpt_ahead(rd_reg, hit_ent_reg);
    end

    assign req_pop   = (state_reg == S_IDLE) && req_valid;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign idle      = (state_reg == S_IDLE);

    // memory read, registered; insert and flag write-back in S_DONE
    always_ff @(posedge clk) begin
        rd_reg   <= mem[rd_idx];
        rd_a_reg <= rd_idx;
        if (state_reg == S_DONE && hit_reg && rq == REQ_SET_EXEC) begin
            mem[hit_idx_reg] <= '{hit_ent_reg.id, hit_ent_reg.arr, hit_ent_reg.tx,
                                  hit_ent_reg.pri, hit_ent_reg.pos, cur_reg.exec_flag};
        end
        else if (state_reg == S_DONE && rq == REQ_INSERT && free_reg) begin
            mem[free_idx_reg] <= '{cur_reg.flow_id, cur_reg.arrival, cur_reg.transmit_len,
                                   cur_reg.prio, cur_reg.orig_position, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        cur_reg   <= req_data;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_LAST: begin
                    // rd_reg holds slot rd_a_reg when rd_v_reg
                    if (rd_v_reg) begin
                        if (valid_reg[rd_a_reg]) begin
                            if (rq == REQ_PEEK || rq == REQ_POP) begin
                                if (better) begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= rd_a_reg;
                                    hit_ent_reg <= rd_reg;
                                end
                            end
                            else if (match && !hit_reg) begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= rd_a_reg;
                                hit_ent_reg <= rd_reg;
                            end
                        end
                        else if (!free_reg) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= rd_a_reg;
                        end
                    end
                    if (state_reg == S_LAST) begin
                        state_reg <= S_DONE;
                        rd_v_reg  <= 1'b0;
                    end
                    else begin
                        rd_v_reg <= 1'b1;
                        if (idx_reg == (AW+1)'(DEPTH - 1)) begin
                            state_reg <= S_LAST;
                        end
                        else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    res_valid_reg <= 1'b1;
                    res_reg <= '0;
                    unique case (rq)
                        REQ_INSERT: begin
                            if (free_reg) begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                count_reg <= count_reg + 1'b1;
                                res_reg <= '{ST_OK, cur_reg.flow_id, cur_reg.arrival,
                                             cur_reg.transmit_len, cur_reg.prio,
                                             cur_reg.orig_position, 1'b0,
                                             7'(count_reg + 1'b1)};
                            end
                            else begin
                                res_reg.status      <= ST_FULL;
                                res_reg.entry_count <= 7'(count_reg);
                            end
                        end
                        REQ_NONE: begin
                            res_reg.status      <= ST_NOTFOUND;
                            res_reg.entry_count <= 7'(count_reg);
                        end
                        default: begin
                            if (hit_reg) begin
                                if (rq == REQ_DEL_ID || rq == REQ_DEL_POS || rq == REQ_POP)
                                begin
                                    valid_reg[hit_idx_reg] <= 1'b0;
                                    count_reg <= count_reg - 1'b1;
                                    res_reg.entry_count <= 7'(count_reg - 1'b1);
                                end
                                else begin
                                    res_reg.entry_count <= 7'(count_reg);
                                end
                                res_reg.status           <= ST_OK;
                                res_reg.out_flow_id      <= hit_ent_reg.id;
                                res_reg.out_arrival      <= hit_ent_reg.arr;
                                res_reg.out_transmit_len <= hit_ent_reg.tx;
                                res_reg.out_prio         <= hit_ent_reg.pri;
                                res_reg.out_position     <= hit_ent_reg.pos;
                                res_reg.out_exec         <= (rq == REQ_SET_EXEC) ?
                                                            cur_reg.exec_flag : hit_ent_reg.ex;
                            end
                            else begin
                                res_reg.status      <= ST_NOTFOUND;
                                res_reg.entry_count <= 7'(count_reg);
                            end
                        end
                    endcase
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: flow priority table request/result check
// Drives directed and random requests, predicts every result in a local
// model of the table and compares the result at each done strobe, printing it field by field on a mismatch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpt_pkg::*;

    localparam int DEPTH     = FPT_DEPTH;
    localparam int N_RANDOM  = 1600;

    // one directed row; check_row set where the answer is typed in
    typedef struct {
        fpt_req_t rq;
        bit       check_row;
        fpt_res_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    fpt_req_t req;
    logic     done;
    fpt_res_t rsp;

    flow_priority_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // shadow table
    fpt_entry_t tbl_ent [DEPTH];
    bit         tbl_vld [DEPTH];
    int         tbl_cnt;

    fpt_res_t   result_q [$];
    int         n_fail;
    int         n_results;
    int         n_sent;
    int         n_pops_ok;
    bit         quiet_phase;
    dir_row_t   rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: ~1700 requests plus idle gaps, many times over
    initial
    begin
        #20ms;
        $display("timeout at %0t, %0d results pending", $time, result_q.size());
        $display("status: fail");
        $finish;
    end

    function automatic logic serves_first(input fpt_entry_t a, input fpt_entry_t b);
        if (a.ex != b.ex)   return a.ex;
        if (a.pri != b.pri) return a.pri < b.pri;
        if (a.arr != b.arr) return a.arr < b.arr;
        if (a.tx != b.tx)   return a.tx < b.tx;
        return a.pos < b.pos;
    endfunction

    function automatic fpt_res_t entry_result(input fpt_entry_t e);
        fpt_res_t r;
        r = '0;
        r.status           = ST_OK;
        r.out_flow_id      = e.id;
        r.out_arrival      = e.arr;
        r.out_transmit_len = e.tx;
        r.out_prio         = e.pri;
        r.out_position     = e.pos;
        r.out_exec         = e.ex;
        return r;
    endfunction

    // apply one request to the shadow table, return the expected result
    function automatic fpt_res_t table_apply(input fpt_req_t q);
        fpt_res_t r;
        int       hit;
        hit = -1;
        r   = '0;
        r.status = ST_NOTFOUND;
        case (req_code_t'(q.req_type))
            REQ_INSERT:
            begin
                for (int i = 0; i < DEPTH && hit < 0; i++)
                    if (!tbl_vld[i]) hit = i;
                if (hit < 0)
                    r.status = ST_FULL;
                else
                begin
                    tbl_vld[hit] = 1'b1;
                    tbl_ent[hit] = '{q.flow_id, q.arrival, q.transmit_len,
                                     q.prio, q.orig_position, 1'b0};
                    tbl_cnt++;
                    r = entry_result(tbl_ent[hit]);
                end
            end
            REQ_DEL_ID, REQ_DEL_POS, REQ_FIND_POS, REQ_SET_EXEC:
            begin
                for (int i = 0; i < DEPTH && hit < 0; i++)
                    if (tbl_vld[i] && ((q.req_type inside {REQ_DEL_ID, REQ_SET_EXEC})
                            ? tbl_ent[i].id == q.flow_id
                            : tbl_ent[i].pos == q.orig_position))
                        hit = i;
                if (hit >= 0)
                begin
                    if (q.req_type == REQ_SET_EXEC)
                        tbl_ent[hit].ex = q.exec_flag;
                    r = entry_result(tbl_ent[hit]);
                    if (q.req_type inside {REQ_DEL_ID, REQ_DEL_POS})
                    begin
                        tbl_vld[hit] = 1'b0;
                        tbl_cnt--;
                    end
                end
            end
            REQ_PEEK, REQ_POP:
            begin
                // strict compare keeps the lowest slot on a full tie
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_vld[i] && (hit < 0 || serves_first(tbl_ent[i], tbl_ent[hit])))
                        hit = i;
                if (hit >= 0)
                begin
                    r = entry_result(tbl_ent[hit]);
                    if (q.req_type == REQ_POP)
                    begin
                        tbl_vld[hit] = 1'b0;
                        tbl_cnt--;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = tbl_cnt[6:0];
        return r;
    endfunction

    function automatic fpt_req_t make_req(input req_code_t op, input logic [7:0] id,
                                          input logic [15:0] arr, input logic [15:0] tx,
                                          input logic [7:0] pri, input logic [7:0] pos,
                                          input logic ex);
        fpt_req_t q;
        q = '{op, id, arr, tx, pri, pos, ex};
        return q;
    endfunction

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            fpt_res_t w;
            n_results++;
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
                n_fail++;
            end
            else
            begin
                w = result_q.pop_front();
                if (rsp !== w)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, w, rsp);
                    $display("    status %0d/%0d id %0d/%0d arr %0d/%0d tx %0d/%0d",
                             w.status, rsp.status, w.out_flow_id, rsp.out_flow_id,
                             w.out_arrival, rsp.out_arrival,
                             w.out_transmit_len, rsp.out_transmit_len);
                    $display("    prio %0d/%0d pos %0d/%0d exec %0d/%0d count %0d/%0d",
                             w.out_prio, rsp.out_prio, w.out_position, rsp.out_position,
                             w.out_exec, rsp.out_exec, w.entry_count, rsp.entry_count);
                    n_fail++;
                end
            end
        end
    end

    task automatic idle_burst();
        int len;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            len = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (len) @(negedge clk);
        end
    endtask

    // present one request and wait until it is taken
    task automatic send_request(input fpt_req_t q, input bit typed, input fpt_res_t want);
        fpt_res_t pred;
        bit       taken;
        idle_burst();
        req   <= q;
        start <= 1'b1;
        // busy only moves on a rising edge, so its value here holds at the next one
        taken = !busy;
        @(posedge clk);
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        pred = table_apply(q);
        if (typed && pred !== want)
        begin
            $display("%0t: directed row mismatch expected %h predicted %h", $time, want, pred);
            n_fail++;
        end
        result_q.push_back(pred);
        n_sent++;
        if (q.req_type == REQ_POP && pred.status == ST_OK) n_pops_ok++;
        @(negedge clk);
    endtask

    // id/pos drawn from a narrow pool so lookups usually hit
    function automatic fpt_req_t random_req(input int fill_bias);
        fpt_req_t  q;
        req_code_t op;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < fill_bias)      op = REQ_INSERT;
        else if (pick < 55)        op = REQ_POP;
        else if (pick < 63)        op = REQ_PEEK;
        else if (pick < 72)        op = REQ_DEL_ID;
        else if (pick < 80)        op = REQ_DEL_POS;
        else if (pick < 88)        op = REQ_FIND_POS;
        else if (pick < 98)        op = REQ_SET_EXEC;
        else                       op = REQ_NONE;
        q = $bits(fpt_req_t)'({$urandom, $urandom});
        q.req_type = op;
        if ($urandom_range(0, 3) != 0)
        begin
            q.flow_id       = 8'($urandom_range(0, 79));
            q.orig_position = 8'($urandom_range(0, 79));
        end
        // narrow keys often, so ties fall through to later keys
        if ($urandom_range(0, 1)) q.prio    = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) q.arrival = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) q.transmit_len = 16'($urandom_range(0, 3));
        return q;
    endfunction

    initial
    begin
        fpt_res_t none_r, full_r;
        int       bias;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        n_fail = 0; n_results = 0; n_sent = 0; n_pops_ok = 0;
        quiet_phase = 1'b0;
        tbl_cnt = 0;
        for (int i = 0; i < DEPTH; i++) tbl_vld[i] = 1'b0;

        none_r = '0; none_r.status = ST_NOTFOUND;
        full_r = '0; full_r.status = ST_FULL; full_r.entry_count = 7'(DEPTH);

        // directed rows: empty table, extremes, flags, unused code
        rows.push_back('{make_req(REQ_PEEK, 0, 0, 0, 0, 0, 0), 1, none_r});
        rows.push_back('{make_req(REQ_POP, 0, 0, 0, 0, 0, 0), 1, none_r});
        rows.push_back('{make_req(REQ_DEL_ID, 8'hff, 0, 0, 0, 0, 0), 1, none_r});
        rows.push_back('{make_req(REQ_NONE, 8'hff, '1, '1, '1, '1, 1), 1, none_r});
        rows.push_back('{make_req(REQ_INSERT, 8'hff, '1, '1, '1, '1, 1), 1,
                         '{ST_OK, 8'hff, 16'hffff, 16'hffff, 8'hff, 8'hff, 1'b0, 7'd1}});
        rows.push_back('{make_req(REQ_INSERT, 0, 0, 0, 0, 0, 0), 1,
                         '{ST_OK, 8'h0, 16'h0, 16'h0, 8'h0, 8'h0, 1'b0, 7'd2}});
        rows.push_back('{make_req(REQ_INSERT, 5, 7, 9, 0, 20, 0), 0, none_r});
        rows.push_back('{make_req(REQ_INSERT, 6, 7, 9, 0, 21, 0), 0, none_r});
        rows.push_back('{make_req(REQ_PEEK, 0, 0, 0, 0, 0, 0), 0, none_r});
        rows.push_back('{make_req(REQ_SET_EXEC, 8'hff, 0, 0, 0, 0, 1), 0, none_r});
        rows.push_back('{make_req(REQ_PEEK, 0, 0, 0, 0, 0, 0), 0, none_r});
        rows.push_back('{make_req(REQ_FIND_POS, 0, 0, 0, 0, 21, 0), 0, none_r});
        rows.push_back('{make_req(REQ_DEL_POS, 0, 0, 0, 0, 99, 0), 0, none_r});
        rows.push_back('{make_req(REQ_SET_EXEC, 8'hff, 0, 0, 0, 0, 0), 0, none_r});
        rows.push_back('{make_req(REQ_DEL_POS, 0, 0, 0, 0, 20, 0), 0, none_r});
        rows.push_back('{make_req(REQ_POP, 0, 0, 0, 0, 0, 0), 0, none_r});
        rows.push_back('{make_req(REQ_DEL_ID, 8'hff, 0, 0, 0, 0, 0), 0, none_r});
        rows.push_back('{make_req(REQ_POP, 0, 0, 0, 0, 0, 0), 0, none_r});
        rows.push_back('{make_req(REQ_POP, 0, 0, 0, 0, 0, 0), 0, none_r});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[k])
            send_request(rows[k].rq, rows[k].check_row, rows[k].want);

        // fill to the top, then one insert past full
        for (int i = 0; i < DEPTH; i++)
            send_request(make_req(REQ_INSERT, 8'(i + 100), 16'($urandom), 16'($urandom),
                                  8'($urandom_range(0, 2)), 8'(i + 100), 0), 0, none_r);
        send_request(make_req(REQ_INSERT, 8'h33, 1, 1, 1, 1, 0), 1, full_r);

        // random phase: drift between filling and draining
        for (int n = 0; n < N_RANDOM; n++)
        begin
            bias = ((n / 200) % 2) ? 20 : 45;
            if (n >= N_RANDOM - 150) quiet_phase = 1'b1;
            send_request(random_req(bias), 0, none_r);
        end

        start <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);

        $display("sent %0d requests, checked %0d results, %0d successful pops",
                 n_sent, n_results, n_pops_ok);
        if (n_fail == 0 && result_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
